// ----- design/evq_pkg.sv -----
// shared constants for the coalescing event queue
// status codes, sizes and entry layout; no dependencies
package evq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int NUM_EVENT_IDS = 64;

  localparam int ID_W    = 8;
  localparam int PARAM_W = 16;
  localparam int TAG_W   = 32;
  localparam int STAT_W  = 3;

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_IDX_W = $clog2(NUM_EVENT_IDS);
  localparam int ENTRY_W  = ID_W + PARAM_W + TAG_W;

  localparam logic [STAT_W-1:0] ST_QUEUED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_MERGED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DELIVERED = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd5;

  localparam logic ACT_PUBLISH = 1'b0;
  localparam logic ACT_POLL    = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PARAM_W-1:0] prm;
    logic [TAG_W-1:0]   tag;
  } entry_t;

endpackage

// ----- design/evq_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module evq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dedup_event_queue_overwrite_oldest.sv -----
// coalescing event fifo: head entry read in the cycle after accept, then updated.
// the result strobe is registered: accept moves the fsm to execute, which sets the done register.
// a new item is accepted only in idle, not while busy; the execute state reads the head entry from
// the entry ram, whose registered data is ready only in the cycle after accept.
// reset clears head, tail, count and the pending bits; the entry ram is not cleared.
// the receiver cannot stall: done_o is a one-cycle strobe.
module dedup_event_queue_overwrite_oldest
  import evq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic [ID_W-1:0]    event_id_i,
  input  logic [PARAM_W-1:0] param_i,
  input  logic [TAG_W-1:0]   data_tag_i,
  output logic               done_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [ID_W-1:0]    out_event_id_o,
  output logic [PARAM_W-1:0] out_param_o,
  output logic [TAG_W-1:0]   out_data_tag_o,
  output logic [ID_W-1:0]    dropped_event_id_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                     state_q, state_d;
  logic [PTR_W-1:0]         head_q, head_d;
  logic [PTR_W-1:0]         tail_q, tail_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [NUM_EVENT_IDS-1:0] pend_q, pend_d;
  logic                     done_q, done_d;

  // captured item
  logic               act_q;
  logic [ID_W-1:0]    id_q;
  logic [PARAM_W-1:0] prm_q;
  logic [TAG_W-1:0]   tag_q;

  logic [STAT_W-1:0]  stat_q, stat_d;
  logic [ID_W-1:0]    oid_q, oid_d;
  logic [PARAM_W-1:0] oprm_q, oprm_d;
  logic [TAG_W-1:0]   otag_q, otag_d;
  logic [ID_W-1:0]    drop_q, drop_d;

  logic   accept;
  logic   we;
  entry_t wentry;
  entry_t head_entry;
  logic   full, empty, bad_id, is_pend;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q == S_EXEC);

  assign wentry = '{id: id_q, prm: prm_q, tag: tag_q};

  evq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tail_q),
    .wdata_i(wentry),
    .raddr_i(head_q),
    .rdata_o(head_entry)
  );

  assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_q == '0);
  assign bad_id  = ({1'b0, id_q} >= (ID_W + 1)'(NUM_EVENT_IDS));
  assign is_pend = pend_q[id_q[ID_IDX_W-1:0]];

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    done_d  = 1'b0;
    we      = 1'b0;
    stat_d  = stat_q;
    oid_d   = oid_q;
    oprm_d  = oprm_q;
    otag_d  = otag_q;
    drop_d  = drop_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        oid_d   = '0;
        oprm_d  = '0;
        otag_d  = '0;
        drop_d  = '0;
        if (act_q == ACT_PUBLISH) begin
          if (bad_id) begin
            stat_d = ST_BAD_ID;
          end else if (is_pend) begin
            stat_d = ST_MERGED;
          end else begin
            stat_d = ST_QUEUED;
            we     = 1'b1;
            tail_d = next_slot(tail_q);
            cnt_d  = cnt_q + 1'b1;
            if (full) begin
              // drop the oldest entry to make room
              stat_d = ST_DROPPED;
              drop_d = head_entry.id;
              pend_d[head_entry.id[ID_IDX_W-1:0]] = 1'b0;
              head_d = next_slot(head_q);
              cnt_d  = cnt_q;
            end
            pend_d[id_q[ID_IDX_W-1:0]] = 1'b1;
          end
        end else begin
          if (empty) begin
            stat_d = ST_EMPTY;
          end else begin
            stat_d = ST_DELIVERED;
            oid_d  = head_entry.id;
            oprm_d = head_entry.prm;
            otag_d = head_entry.tag;
            pend_d[head_entry.id[ID_IDX_W-1:0]] = 1'b0;
            head_d = next_slot(head_q);
            cnt_d  = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      id_q  <= event_id_i;
      prm_q <= param_i;
      tag_q <= data_tag_i;
    end
    stat_q <= stat_d;
    oid_q  <= oid_d;
    oprm_q <= oprm_d;
    otag_q <= otag_d;
    drop_q <= drop_d;
  end

  assign done_o             = done_q;
  assign status_o           = stat_q;
  assign out_event_id_o     = oid_q;
  assign out_param_o        = oprm_q;
  assign out_data_tag_o     = otag_q;
  assign dropped_event_id_o = drop_q;

  // every queued id has exactly one pending bit
  a_pend_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pend_q) == 32'(cnt_q))
    else $error("pending bits disagree with entry count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("no result strobe after execute cycle");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

endmodule
